>>> rtl/core/cofe_pkg.sv
`default_nettype none
package cofe_pkg;

  // Result kinds
  localparam logic [2:0] K_PATH  = 3'd0;
  localparam logic [2:0] K_QUERY = 3'd1;
  localparam logic [2:0] K_SEP   = 3'd2;
  localparam logic [2:0] K_PAY   = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;
  localparam logic [2:0] K_END   = 3'd5;

  // Option numbers and extension bases
  localparam logic [16:0] OPT_URI_PATH  = 17'd11;
  localparam logic [16:0] OPT_URI_QUERY = 17'd15;
  localparam logic [16:0] EXT1_BASE     = 17'd13;
  localparam logic [16:0] EXT2_BASE     = 17'd269;
  localparam logic [3:0]  NIB_EXT1      = 4'd13;
  localparam logic [3:0]  NIB_EXT2      = 4'd14;
  localparam logic [3:0]  NIB_SPECIAL   = 4'hF;
  localparam logic [7:0]  SPACE_CHAR    = 8'd32;

  // Option kinds held while a value is read
  localparam logic [1:0] OK_NONE  = 2'd0;
  localparam logic [1:0] OK_PATH  = 2'd1;
  localparam logic [1:0] OK_QUERY = 2'd2;

  // Job queue between parser and result stage
  localparam int JobDepth = 4;
  localparam int JobPtrW  = $clog2(JobDepth);
  localparam int JobCntW  = $clog2(JobDepth + 1);

  // Results caused by one input word
  typedef struct packed {
    logic       has_data;
    logic       has_sep;
    logic       has_end;
    logic [7:0] data_char;
    logic [2:0] data_kind;
  } job_t;

  // Queue status seen by the parser and the result stage
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

>>> rtl/core/coap_option_field_extractor.sv
`default_nettype none
// Channel  | Handshake      | Fields                     | Word
// ---------+----------------+----------------------------+---------------------------
// input    | push / full    | in_byte[7:0], last_byte    | one message byte
// result   | pop / empty    | out_char[7:0], kind[2:0],  | one extracted byte,
//          |                | is_last                    | separator, error or end
//
// The parser takes one byte per cycle while the queue is not full and turns it
// into a job of up to three results; jobs wait in a four-entry queue and the
// result stage hands out one result per cycle. Each result of a byte takes its
// own pop, so the sustained rate is one byte per cycle while results average
// at most one. full is high while the job queue is full. Reset is synchronous
// and returns the parser to the header and drops all queued and pending results.
module coap_option_field_extractor (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_char,
  output logic [2:0]      kind,
  output logic            is_last
);
  import cofe_pkg::*;

  logic   job_push;
  logic   job_pop;
  job_t   job_in;
  job_t   job_head;
  qstat_t qstat;

  assign full = qstat.full;

  // Parse bytes into jobs
  cofe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .qstat     (qstat),
    .job_push  (job_push),
    .job       (job_in)
  );

  // Buffer jobs
  cofe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_push),
    .wr_job (job_in),
    .rd     (job_pop),
    .rd_job (job_head),
    .qstat  (qstat)
  );

  // Hand out results
  cofe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (job_head),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .kind     (kind),
    .is_last  (is_last)
  );

endmodule
`default_nettype wire

>>> rtl/core/cofe_front.sv
`default_nettype none
module cofe_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    in_byte,
  input  wire logic          last_byte,
  input  wire cofe_pkg::qstat_t qstat,
  output logic               job_push,
  output cofe_pkg::job_t     job
);
  import cofe_pkg::*;

  typedef enum logic [6:0] {
    PH_HEADER   = 7'b0000001,
    PH_TOKEN    = 7'b0000010,
    PH_OPT_HDR  = 7'b0000100,
    PH_DELTA_EX = 7'b0001000,
    PH_LEN_EX   = 7'b0010000,
    PH_VALUE    = 7'b0100000,
    PH_PAYLOAD  = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [3:0]  token_left, token_left_next;
  logic [16:0] option_number, option_number_next;
  logic [7:0]  ext_acc, ext_acc_next;
  logic [3:0]  pend_len, pend_len_next;
  logic [16:0] value_left, value_left_next;
  logic [1:0]  option_kind, option_kind_next;
  logic        payload_stopped, payload_stopped_next;

  logic        accept;
  logic [3:0]  delta_nib;
  logic [3:0]  len_nib;
  logic        ext_done;
  logic [16:0] ext_val;
  logic [16:0] num_addend;
  logic [16:0] num_sum;
  logic [16:0] vl_dec;
  logic [3:0]  tl_dec;

  // Classify an option number for value extraction
  function automatic logic [1:0] kind_of(input logic [16:0] num);
    logic [1:0] k;
    k = OK_NONE;
    if (num == OPT_URI_PATH) begin
      k = OK_PATH;
    end else if (num == OPT_URI_QUERY) begin
      k = OK_QUERY;
    end
    return k;
  endfunction

  assign accept    = push && !qstat.full;
  assign delta_nib = in_byte[7:4];
  assign len_nib   = in_byte[3:0];

  // Decode an extension word: one byte (+13) or two big-endian bytes (+269)
  always_comb begin
    ext_done = (byte_count != 2'd2);
    if (byte_count == 2'd1) begin
      ext_val = {9'd0, in_byte} + EXT1_BASE;
    end else begin
      ext_val = {1'b0, ext_acc, in_byte} + EXT2_BASE;
    end
  end

  // Advance the running option number
  assign num_addend = (phase == PH_OPT_HDR) ? {13'd0, delta_nib} : ext_val;
  assign num_sum    = option_number + num_addend;
  assign vl_dec     = (value_left != 17'd0) ? value_left - 17'd1 : value_left;
  assign tl_dec     = (token_left != 4'd0) ? token_left - 4'd1 : token_left;

  // Parse one word
  always_comb begin
    phase_next           = phase;
    byte_count_next      = byte_count;
    token_left_next      = token_left;
    option_number_next   = option_number;
    ext_acc_next         = ext_acc;
    pend_len_next        = pend_len;
    value_left_next      = value_left;
    option_kind_next     = option_kind;
    payload_stopped_next = payload_stopped;
    job                  = '0;

    case (phase)
      PH_HEADER: begin
        if (byte_count == 2'd0) begin
          token_left_next = len_nib;
        end
        if (byte_count == 2'd3) begin
          byte_count_next = 2'd0;
          phase_next      = (token_left == 4'd0) ? PH_OPT_HDR : PH_TOKEN;
        end else begin
          byte_count_next = byte_count + 2'd1;
        end
      end
      PH_TOKEN: begin
        token_left_next = tl_dec;
        if (tl_dec == 4'd0) begin
          phase_next = PH_OPT_HDR;
        end
      end
      PH_OPT_HDR: begin
        if (delta_nib == NIB_SPECIAL) begin
          job.has_sep          = 1'b1;
          payload_stopped_next = 1'b0;
          phase_next           = PH_PAYLOAD;
        end else begin
          pend_len_next = len_nib;
          if (len_nib == NIB_SPECIAL) begin
            job.has_data  = 1'b1;
            job.data_char = 8'd0;
            job.data_kind = K_ERR;
          end
          if (delta_nib == NIB_EXT1) begin
            phase_next      = PH_DELTA_EX;
            byte_count_next = 2'd1;
          end else if (delta_nib == NIB_EXT2) begin
            phase_next      = PH_DELTA_EX;
            byte_count_next = 2'd2;
          end else begin
            option_number_next = num_sum;
            if (len_nib == NIB_EXT1) begin
              phase_next      = PH_LEN_EX;
              byte_count_next = 2'd1;
            end else if (len_nib == NIB_EXT2) begin
              phase_next      = PH_LEN_EX;
              byte_count_next = 2'd2;
            end else begin
              value_left_next  = {13'd0, len_nib};
              option_kind_next = kind_of(num_sum);
              phase_next       = (len_nib == 4'd0) ? PH_OPT_HDR : PH_VALUE;
            end
          end
        end
      end
      PH_DELTA_EX: begin
        if (!ext_done) begin
          ext_acc_next    = in_byte;
          byte_count_next = 2'd3;
        end else begin
          option_number_next = num_sum;
          if (pend_len == NIB_EXT1) begin
            phase_next      = PH_LEN_EX;
            byte_count_next = 2'd1;
          end else if (pend_len == NIB_EXT2) begin
            phase_next      = PH_LEN_EX;
            byte_count_next = 2'd2;
          end else begin
            value_left_next  = {13'd0, pend_len};
            option_kind_next = kind_of(num_sum);
            phase_next       = (pend_len == 4'd0) ? PH_OPT_HDR : PH_VALUE;
          end
        end
      end
      PH_LEN_EX: begin
        if (!ext_done) begin
          ext_acc_next    = in_byte;
          byte_count_next = 2'd3;
        end else begin
          value_left_next  = ext_val;
          option_kind_next = kind_of(option_number);
          phase_next       = (ext_val == 17'd0) ? PH_OPT_HDR : PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (option_kind == OK_PATH) begin
          job.has_data  = 1'b1;
          job.data_char = in_byte;
          job.data_kind = K_PATH;
        end else if (option_kind == OK_QUERY) begin
          job.has_data  = 1'b1;
          job.data_char = in_byte;
          job.data_kind = K_QUERY;
        end
        value_left_next = vl_dec;
        if (vl_dec == 17'd0) begin
          job.has_sep = (option_kind == OK_QUERY);
          phase_next  = PH_OPT_HDR;
        end
      end
      PH_PAYLOAD: begin
        if (!payload_stopped) begin
          if (in_byte == 8'd0) begin
            payload_stopped_next = 1'b1;
          end else begin
            job.has_data  = 1'b1;
            job.data_char = in_byte;
            job.data_kind = K_PAY;
          end
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // Close the message and return to the header
    if (last_byte) begin
      job.has_end          = 1'b1;
      phase_next           = PH_HEADER;
      byte_count_next      = 2'd0;
      token_left_next      = 4'd0;
      option_number_next   = 17'd0;
      ext_acc_next         = 8'd0;
      pend_len_next        = 4'd0;
      value_left_next      = 17'd0;
      option_kind_next     = OK_NONE;
      payload_stopped_next = 1'b0;
    end
  end

  // Queue only words that cause results
  assign job_push = accept && (job.has_data || job.has_sep || job.has_end);

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_count      <= 2'd0;
      token_left      <= 4'd0;
      option_number   <= 17'd0;
      ext_acc         <= 8'd0;
      pend_len        <= 4'd0;
      value_left      <= 17'd0;
      option_kind     <= OK_NONE;
      payload_stopped <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_count      <= byte_count_next;
      token_left      <= token_left_next;
      option_number   <= option_number_next;
      ext_acc         <= ext_acc_next;
      pend_len        <= pend_len_next;
      value_left      <= value_left_next;
      option_kind     <= option_kind_next;
      payload_stopped <= payload_stopped_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cofe_queue.sv
`default_nettype none
module cofe_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire cofe_pkg::job_t   wr_job,
  input  wire logic             rd,
  output cofe_pkg::job_t        rd_job,
  output cofe_pkg::qstat_t      qstat
);
  import cofe_pkg::*;

  job_t               store [JobDepth];
  logic [JobPtrW-1:0] wr_ptr;
  logic [JobPtrW-1:0] rd_ptr;
  logic [JobCntW-1:0] count;
  logic               wr_ok;
  logic               rd_ok;

  assign qstat.full  = (count == JobCntW'(JobDepth));
  assign qstat.empty = (count == '0);
  assign wr_ok       = wr && !qstat.full;
  assign rd_ok       = rd && !qstat.empty;
  assign rd_job      = store[rd_ptr];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      store[wr_ptr] <= wr_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == JobPtrW'(JobDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == JobPtrW'(JobDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_ok && !rd_ok) begin
        count <= count + 1'b1;
      end else if (rd_ok && !wr_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= JobCntW'(JobDepth))
    else $error("job queue count beyond depth");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_ok && !rd_ok) |=> (count == $past(count) + 1'b1))
    else $error("job queue write lost");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == JobCntW'(JobDepth)) |-> (wr_ptr == rd_ptr))
    else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

>>> rtl/core/cofe_back.sv
`default_nettype none
module cofe_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cofe_pkg::qstat_t qstat,
  input  wire cofe_pkg::job_t   head,
  output logic                  job_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_char,
  output logic [2:0]            kind,
  output logic                  is_last
);
  import cofe_pkg::*;

  // Pending results of the current job: bit 0 data, bit 1 separator, bit 2 end
  logic [2:0] rem, rem_next;
  logic [2:0] rem_after;
  logic [7:0] data_char;
  logic [2:0] data_kind;
  logic       pop_ok;
  logic       load;

  assign empty     = (rem == 3'b000);
  assign pop_ok    = pop && !empty;
  assign rem_after = rem & (rem - 3'd1);
  assign load      = empty || (pop_ok && rem_after == 3'b000);
  assign job_pop   = load && !qstat.empty;

  // Show the oldest pending result
  always_comb begin
    if (rem[0]) begin
      out_char = data_char;
      kind     = data_kind;
      is_last  = 1'b0;
    end else if (rem[1]) begin
      out_char = SPACE_CHAR;
      kind     = K_SEP;
      is_last  = 1'b0;
    end else begin
      out_char = 8'd0;
      kind     = K_END;
      is_last  = 1'b1;
    end
  end

  // Drop the delivered result or take the next job
  always_comb begin
    rem_next = rem;
    if (load) begin
      if (qstat.empty) begin
        rem_next = 3'b000;
      end else begin
        rem_next = {head.has_end, head.has_sep, head.has_data};
      end
    end else if (pop_ok) begin
      rem_next = rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'b000;
    end else begin
      rem <= rem_next;
    end
  end

  // Hold the data result of the current job
  always_ff @(posedge clk) begin
    if (job_pop) begin
      data_char <= head.data_char;
      data_kind <= head.data_kind;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == K_END) |-> is_last)
    else $error("end result without last flag");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(out_char)))
    else $error("stalled result changed");

  a_no_empty_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> !empty)
    else $error("queued job carried no result");

endmodule
`default_nettype wire
